// ===== src/xorshift_random_offset_generator_assert.svh =====
// Assertion macros shared by the generator RTL.
`ifndef XORSHIFT_RANDOM_OFFSET_GENERATOR_ASSERT_SVH
`define XORSHIFT_RANDOM_OFFSET_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define XROG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define XROG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/xrog_pkg.sv =====
`timescale 1ns / 1ps

package xrog_pkg;

  // Request modes; the fourth code is ignored.
  typedef enum logic [1:0] {
    MODE_OFFSET = 2'd0,
    MODE_RANGE  = 2'd1,
    MODE_RESEED = 2'd2
  } mode_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_DSTART,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_e;

  // Configuration register map (64-bit registers at 8-byte spacing).
  localparam int unsigned ADDR_W = 4;
  localparam logic REG_SEED_LOW  = 1'b0;
  localparam logic REG_SEED_HIGH = 1'b1;

  // Generator state after reset.
  localparam logic [63:0] SEED0_RESET = 64'hDEADBEEFCAFEBABE;
  localparam logic [63:0] SEED1_RESET = 64'h0123456789ABCDEF;

  // xorshift128+ shift amounts.
  localparam int unsigned SHIFT_A = 23;
  localparam int unsigned SHIFT_B = 17;
  localparam int unsigned SHIFT_C = 26;

  // Step control from the sequencer to the generator.
  typedef struct packed {
    logic step;
    logic xor_w0;
    logic xor_w1;
  } gen_ctrl_t;

  // Seed write from the configuration port.
  typedef struct packed {
    logic        wr_w0;
    logic        wr_w1;
    logic [63:0] data;
  } cfg_wr_t;

endpackage

// ===== src/xrog_if.sv =====
`timescale 1ns / 1ps

// Request channel.
interface xrog_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [5:0]  shift_bits;
  logic [63:0] range_low;
  logic [63:0] range_high;
  logic [63:0] entropy_word;

  modport source (
    output valid, mode, shift_bits, range_low, range_high, entropy_word,
    input  ready
  );
  modport sink (
    input  valid, mode, shift_bits, range_low, range_high, entropy_word,
    output ready
  );
endinterface

// Result channel.
interface xrog_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] rand_value;

  modport source (
    output valid, rand_value,
    input  ready
  );
  modport sink (
    input  valid, rand_value,
    output ready
  );
endinterface

// ===== src/xorshift_random_offset_generator.sv =====
`timescale 1ns / 1ps
// Xorshift random offset generator.
// Requests arrive on req_i (valid/ready); a transfer takes one request.
// Results leave on rsp_o (valid/ready) from an output register, so the
// next request is taken while a result still waits for its transfer.
// Offset mode: three generator steps, one per cycle, then masking and
// alignment. Range mode: generator steps, then the bit-serial
// remainder unit, which retires one dividend bit per cycle. Zero offset
// bits and empty ranges skip the generator and answer directly. Reseed
// steps the generator and gives no result; mode 3 is dropped at once.
// One request is worked on at a time.
// The APB port writes and reads the two generator words at byte addresses
// 0 and 8; write them only while the block is idle.
// Reset loads the fixed seed words and empties the output register.
// A stalled receiver holds the result in the output register; a finished
// request then waits in its last state until the register frees up.
`include "xorshift_random_offset_generator_assert.svh"

module xorshift_random_offset_generator import xrog_pkg::*; #(
  parameter int unsigned ALIGN_LOG2      = 12,
  parameter int unsigned MAX_OFFSET_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  xrog_req_if.sink          req_i,
  xrog_rsp_if.source        rsp_o
);

  localparam logic [63:0] AlignMask = 64'((65'd1 << ALIGN_LOG2) - 65'd1);
  localparam logic [5:0]  MaxBits   = 6'(MAX_OFFSET_BITS);

  state_e      state_q, state_d;
  mode_e       mode_q;
  logic [5:0]  bits_q;
  logic [1:0]  steps_q;
  logic [63:0] lo_q, hi_q, span_q, mix_q, accum_q, result_q;
  logic        rsp_valid_q;
  logic [63:0] rsp_data_q;

  gen_ctrl_t   gen_ctrl;
  cfg_wr_t     cfg_wr;
  logic [63:0] word0, word1, step_x;
  logic        accept, div_start, div_done, load_out;
  logic [63:0] rem;
  logic [5:0]  sat_bits;
  logic [63:0] bit_mask;
  logic        reg_idx;

  // Configuration port decode
  assign pready  = 1'b1;
  assign reg_idx = paddr[3];
  always_comb begin
    cfg_wr       = '0;
    cfg_wr.data  = pwdata;
    if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_SEED_LOW:  cfg_wr.wr_w0 = 1'b1;
        REG_SEED_HIGH: cfg_wr.wr_w1 = 1'b1;
        default:       cfg_wr = cfg_wr;
      endcase
    end
  end
  assign prdata = (reg_idx == REG_SEED_HIGH) ? word1 : word0;

  xrog_gen u_gen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (gen_ctrl),
    .mix_i      (mix_q),
    .cfg_i      (cfg_wr),
    .word0_o    (word0),
    .word1_o    (word1),
    .step_out_o (step_x)
  );

  xrog_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (accum_q),
    .divisor_i  (span_q),
    .done_o     (div_done),
    .rem_o      (rem)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign sat_bits    = (req_i.shift_bits > MaxBits) ? MaxBits : req_i.shift_bits;
  assign bit_mask    = (64'd1 << bits_q) - 64'd1;

  // Sequencer: next state and step controls
  always_comb begin
    state_d   = state_q;
    gen_ctrl  = '0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_e'(req_i.mode))
            MODE_OFFSET: state_d = (req_i.shift_bits == '0) ? ST_DONE : ST_STEP;
            MODE_RANGE:  state_d = (req_i.range_low < req_i.range_high) ? ST_STEP
                                                                         : ST_DONE;
            MODE_RESEED: state_d = ST_STEP;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_STEP: begin
        gen_ctrl.step   = 1'b1;
        gen_ctrl.xor_w0 = (mode_q == MODE_RESEED) && (steps_q == 2'd2);
        gen_ctrl.xor_w1 = (mode_q == MODE_RESEED) && (steps_q == 2'd1);
        if (steps_q == 2'd1) begin
          case (mode_q)
            MODE_OFFSET: state_d = ST_FIN;
            MODE_RANGE:  state_d = ST_DSTART;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
    end else if (accept) begin
      steps_q <= (mode_e'(req_i.mode) == MODE_OFFSET) ? 2'd3 : 2'd2;
    end else if (gen_ctrl.step) begin
      steps_q <= steps_q - 2'd1;
    end
  end

  // Request payload, accumulator and result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= mode_e'(req_i.mode);
      bits_q   <= sat_bits;
      lo_q     <= req_i.range_low;
      hi_q     <= req_i.range_high;
      mix_q    <= req_i.entropy_word;
      accum_q  <= (mode_e'(req_i.mode) == MODE_OFFSET) ? req_i.entropy_word : 64'd0;
      result_q <= (mode_e'(req_i.mode) == MODE_RANGE) ? req_i.range_low : 64'd0;
    end
    if (gen_ctrl.step) begin
      accum_q <= accum_q ^ step_x;
      span_q  <= hi_q - lo_q;
    end
    if (state_q == ST_FIN) begin
      if (mode_q == MODE_OFFSET) begin
        result_q <= (accum_q & bit_mask) << ALIGN_LOG2;
      end else begin
        result_q <= (lo_q + rem) & ~AlignMask;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (load_out) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      rsp_data_q <= result_q;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.rand_value = rsp_data_q;

  `XROG_ASSERT_IMPL(a_div_done_in_div, clk_i, rst_ni, div_done, state_q == ST_DIV,
                    "remainder finished outside the divide state")
  `XROG_ASSERT_NEXT(a_reseed_pair, clk_i, rst_ni, gen_ctrl.xor_w0, gen_ctrl.xor_w1,
                    "reseed second step did not follow the first")
  `XROG_ASSERT_IMPL(a_range_aligned, clk_i, rst_ni,
                    (state_q == ST_DONE) && (mode_q == MODE_RANGE) && (lo_q < hi_q),
                    (result_q & AlignMask) == 64'd0,
                    "range result not aligned")
  `XROG_ASSERT_IMPL(a_offset_width, clk_i, rst_ni,
                    (state_q == ST_DONE) && (mode_q == MODE_OFFSET),
                    (result_q >> (ALIGN_LOG2 + MAX_OFFSET_BITS)) == 64'd0,
                    "offset result wider than allowed")

endmodule

// ===== src/xrog_gen.sv =====
`timescale 1ns / 1ps

module xrog_gen import xrog_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  gen_ctrl_t   ctrl_i,
  input  logic [63:0] mix_i,
  input  cfg_wr_t     cfg_i,
  output logic [63:0] word0_o,
  output logic [63:0] word1_o,
  output logic [63:0] step_out_o
);

  logic [63:0] w0_q, w0_d;
  logic [63:0] w1_q, w1_d;
  logic [63:0] a_mix;
  logic [63:0] new_w1;
  logic [63:0] step_x;

  // One generator step
  assign a_mix  = w0_q ^ (w0_q << SHIFT_A);
  assign new_w1 = a_mix ^ w1_q ^ (a_mix >> SHIFT_B) ^ (w1_q >> SHIFT_C);
  assign step_x = new_w1 + w1_q;

  // Select next state words: seed write, step, or hold
  always_comb begin
    w0_d = w0_q;
    w1_d = w1_q;
    if (ctrl_i.step) begin
      w0_d = w1_q;
      w1_d = new_w1;
      if (ctrl_i.xor_w0) begin
        w0_d = w1_q ^ mix_i ^ step_x;
      end
      if (ctrl_i.xor_w1) begin
        w1_d = new_w1 ^ step_x;
      end
    end
    if (cfg_i.wr_w0) begin
      w0_d = cfg_i.data;
    end
    if (cfg_i.wr_w1) begin
      w1_d = cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w0_q <= SEED0_RESET;
      w1_q <= SEED1_RESET;
    end else begin
      w0_q <= w0_d;
      w1_q <= w1_d;
    end
  end

  assign word0_o    = w0_q;
  assign word1_o    = w1_q;
  assign step_out_o = step_x;

endmodule

// ===== src/xrog_div.sv =====
`timescale 1ns / 1ps

// Bit-serial restoring remainder: one dividend bit per cycle.
module xrog_div import xrog_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [63:0] divisor_i,
  output logic        done_o,
  output logic [63:0] rem_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic [63:0] dvd_q;
  logic [63:0] dsr_q;
  logic [63:0] rem_q;
  logic [64:0] rem_sh;
  logic [64:0] diff;

  // Shift in the next dividend bit and try a subtract
  assign rem_sh = {rem_q, dvd_q[63]};
  assign diff   = rem_sh - {1'b0, dsr_q};
  assign done_o = busy_q && (cnt_q == 6'd63);

  // Control: count the 64 bit steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: shift register for the dividend, partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[62:0], 1'b0};
      rem_q <= diff[64] ? rem_sh[63:0] : diff[63:0];
    end
  end

  assign rem_o = rem_q;

endmodule

// ===== dv/tb_xorshift_random_offset_generator.sv =====
`timescale 1ns / 1ps

module tb_xorshift_random_offset_generator import xrog_pkg::*;;

  localparam int unsigned ALIGN_LOG2      = 12;
  localparam int unsigned MAX_OFFSET_BITS = 32;
  localparam logic [1:0]  MODE_UNUSED     = 2'd3;

  // Register byte addresses of the two seed words
  localparam logic [ADDR_W-1:0] ADDR_SEED_LOW  = 4'd0;
  localparam logic [ADDR_W-1:0] ADDR_SEED_HIGH = 4'd8;

  // Generator words after reset and the xorshift128+ shift amounts
  localparam logic [63:0] RESET_WORD0 = 64'hDEAD_BEEF_CAFE_BABE;
  localparam logic [63:0] RESET_WORD1 = 64'h0123_4567_89AB_CDEF;
  localparam int unsigned XS_SHL   = 23;
  localparam int unsigned XS_SHR_A = 17;
  localparam int unsigned XS_SHR_B = 26;

  localparam int unsigned SETTLE_CYCLES = 100;
  localparam longint unsigned TIMEOUT_NS = 64'd20_000_000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  shift_bits;
    logic [63:0] range_low;
    logic [63:0] range_high;
    logic [63:0] entropy_word;
  } rng_request_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [63:0]       pwdata;
  logic [63:0]       prdata;
  logic              pready;

  xrog_req_if req_bus ();
  xrog_rsp_if rsp_bus ();

  // Predicted generator state
  logic [63:0] model_w0;
  logic [63:0] model_w1;

  rng_request_t pending_requests[$];
  logic [63:0]  expected_values[$];

  int unsigned send_idle_pct = 7;
  int unsigned recv_idle_pct = 60;
  int unsigned error_count    = 0;
  int unsigned results_checked = 0;
  int unsigned readback_count = 0;
  int unsigned offset_count   = 0;
  int unsigned range_count    = 0;
  int unsigned reseed_count   = 0;
  int unsigned ignored_count  = 0;

  xorshift_random_offset_generator #(
    .ALIGN_LOG2     (ALIGN_LOG2),
    .MAX_OFFSET_BITS(MAX_OFFSET_BITS)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void log_error(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Advance the predicted generator by one xorshift128+ step
  function automatic logic [63:0] advance_generator();
    logic [63:0] a;
    logic [63:0] b;
    a = model_w0;
    b = model_w1;
    model_w0 = b;
    a = a ^ (a << XS_SHL);
    model_w1 = a ^ b ^ (a >> XS_SHR_A) ^ (b >> XS_SHR_B);
    return model_w1 + b;
  endfunction

  // Compute the rand_value a request yields; returns 0 when it yields none
  function automatic bit predict_rand_value(input rng_request_t rq, output logic [63:0] value);
    logic [63:0] mix;
    logic [63:0] span;
    logic [63:0] step_out;
    int unsigned nbits;
    value = '0;
    case (rq.mode)
      MODE_OFFSET: begin
        // zero bits: answer 0 without stepping
        if (rq.shift_bits != 6'd0) begin
          nbits = (rq.shift_bits > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : rq.shift_bits;
          mix = advance_generator();
          mix ^= advance_generator();
          mix ^= advance_generator();
          mix ^= rq.entropy_word;
          value = (mix & ((64'd1 << nbits) - 64'd1)) << ALIGN_LOG2;
        end
        return 1'b1;
      end
      MODE_RANGE: begin
        // empty range: answer the low bound as is, no stepping
        if (rq.range_low >= rq.range_high) begin
          value = rq.range_low;
        end else begin
          span = rq.range_high - rq.range_low;
          mix = advance_generator();
          mix ^= advance_generator();
          value = (rq.range_low + (mix % span)) & ~((64'd1 << ALIGN_LOG2) - 64'd1);
        end
        return 1'b1;
      end
      MODE_RESEED: begin
        step_out = advance_generator();
        model_w0 ^= rq.entropy_word ^ step_out;
        step_out = advance_generator();
        model_w1 ^= step_out;
        return 1'b0;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  function automatic rng_request_t random_request();
    rng_request_t rq;
    int unsigned pick;
    rq.mode         = MODE_OFFSET;
    rq.shift_bits   = 6'($urandom_range(63));
    rq.range_low    = rand64();
    rq.range_high   = rand64();
    rq.entropy_word = rand64();
    pick = $urandom_range(99);
    if (pick < 38) begin
      // favor bit counts that do real work
      if ($urandom_range(2) != 0) rq.shift_bits = 6'($urandom_range(32, 1));
    end else if (pick < 80) begin
      rq.mode = MODE_RANGE;
      case ($urandom_range(4))
        0: rq.range_high = rq.range_low + 64'($urandom_range(8192, 1));
        1: ;
        2: begin
          rq.range_low  = '0;
          rq.range_high = rq.range_high >> $urandom_range(63);
        end
        3: rq.range_high = rq.range_low;
        default: begin
          rq.range_low  = rq.range_low >> $urandom_range(63);
          rq.range_high = '1;
        end
      endcase
    end else if (pick < 95) begin
      rq.mode = MODE_RESEED;
    end else begin
      rq.mode = MODE_UNUSED;
    end
    return rq;
  endfunction

  function automatic void queue_request(logic [1:0] mode, logic [5:0] bits, logic [63:0] lo,
                                        logic [63:0] hi, logic [63:0] ent);
    rng_request_t rq;
    rq = '{mode: mode, shift_bits: bits, range_low: lo, range_high: hi, entropy_word: ent};
    pending_requests.push_back(rq);
  endfunction

  // Request driver: present the next queued item once the previous transfer is done
  always @(posedge clk_i) begin : drive_requests
    rng_request_t next_req;
    if (rst_ni) begin
      if (!req_bus.valid || req_bus.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_requests.pop_front();
          req_bus.valid        <= 1'b1;
          req_bus.mode         <= next_req.mode;
          req_bus.shift_bits   <= next_req.shift_bits;
          req_bus.range_low    <= next_req.range_low;
          req_bus.range_high   <= next_req.range_high;
          req_bus.entropy_word <= next_req.entropy_word;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: predict on each request transfer, check each result transfer
  always @(posedge clk_i) begin : check_results
    rng_request_t taken;
    logic [63:0]  predicted;
    logic [63:0]  oldest;
    if (rst_ni) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (req_bus.valid && req_bus.ready) begin
        taken = '{mode: req_bus.mode, shift_bits: req_bus.shift_bits,
                  range_low: req_bus.range_low, range_high: req_bus.range_high,
                  entropy_word: req_bus.entropy_word};
        case (taken.mode)
          MODE_OFFSET: offset_count++;
          MODE_RANGE:  range_count++;
          MODE_RESEED: reseed_count++;
          default:     ignored_count++;
        endcase
        if (predict_rand_value(taken, predicted)) expected_values.push_back(predicted);
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_values.size() == 0) begin
          log_error($sformatf("unexpected result rand_value=%h", rsp_bus.rand_value));
        end else begin
          oldest = expected_values.pop_front();
          results_checked++;
          if (rsp_bus.rand_value !== oldest) begin
            log_error($sformatf("rand_value expected %h, got %h", oldest, rsp_bus.rand_value));
          end
        end
      end
    end
  end

  // One APB transfer: setup cycle, then access cycle until pready
  task automatic apb_access(input logic wr_access, input logic [ADDR_W-1:0] addr,
                            input logic [63:0] wdata, output logic [63:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr_access;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    rdata = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read both generator words and compare with the predicted state
  task automatic check_seeds();
    logic [63:0] word;
    apb_access(1'b0, ADDR_SEED_LOW, '0, word);
    if (word !== model_w0) log_error($sformatf("word0 read %h, expected %h", word, model_w0));
    apb_access(1'b0, ADDR_SEED_HIGH, '0, word);
    if (word !== model_w1) log_error($sformatf("word1 read %h, expected %h", word, model_w1));
    readback_count += 2;
  endtask

  task automatic load_seeds(input logic [63:0] w0, input logic [63:0] w1);
    logic [63:0] unused_rd;
    check_seeds();
    apb_access(1'b1, ADDR_SEED_LOW, w0, unused_rd);
    model_w0 = w0;
    apb_access(1'b1, ADDR_SEED_HIGH, w1, unused_rd);
    model_w1 = w1;
    check_seeds();
  endtask

  // Hold until every item is taken and every result is in, then let a reseed finish
  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || req_bus.valid || expected_values.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) pending_requests.push_back(random_request());
    wait_for_drain();
  endtask

  initial begin
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    req_bus.valid        = 1'b0;
    req_bus.mode         = MODE_OFFSET;
    req_bus.shift_bits   = '0;
    req_bus.range_low    = '0;
    req_bus.range_high   = '0;
    req_bus.entropy_word = '0;
    rsp_bus.ready        = 1'b0;
    model_w0             = RESET_WORD0;
    model_w1             = RESET_WORD1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part on the reset seeds
    check_seeds();
    queue_request(MODE_OFFSET, 6'd0, '0, '0, '1);
    queue_request(MODE_OFFSET, 6'd1, '0, '0, '0);
    queue_request(MODE_OFFSET, 6'd12, '1, '1, 64'h0F1E_2D3C_4B5A_6978);
    queue_request(MODE_OFFSET, 6'd32, '0, '0, '1);
    queue_request(MODE_OFFSET, 6'd33, '1, '0, '0);
    queue_request(MODE_OFFSET, 6'd63, '0, '1, '1);
    queue_request(MODE_OFFSET, 6'd20, '0, '0, 64'hA5A5_A5A5_5A5A_5A5A);
    queue_request(MODE_RANGE, '1, '0, '1, '1);
    queue_request(MODE_RANGE, '0, 64'h1234, 64'h1234, '0);
    queue_request(MODE_RANGE, '0, '1, '0, '0);
    queue_request(MODE_RANGE, '0, '1, '1, '1);
    queue_request(MODE_RANGE, '0, 64'd5, 64'd6, '0);
    queue_request(MODE_RANGE, '0, 64'd0, 64'd1, '0);
    queue_request(MODE_RANGE, '0, 64'd100, 64'd4196, '0);
    queue_request(MODE_RANGE, '0, 64'h1000, 64'h2000, '0);
    queue_request(MODE_RANGE, '0, 64'hFFFF_FFFF_FFFF_EC77, '1, '0);
    queue_request(MODE_RESEED, '0, '0, '0, '0);
    queue_request(MODE_RESEED, '1, '1, '1, '1);
    queue_request(MODE_UNUSED, '1, '1, '0, '1);
    queue_request(MODE_UNUSED, '0, '0, '0, '0);
    queue_request(MODE_OFFSET, 6'd32, '0, '0, '0);
    queue_request(MODE_RANGE, '0, '0, '1, '0);
    wait_for_drain();

    // Random part over several seed settings and idling profiles
    load_seeds('1, '1);
    run_phase(7, 60, 180);
    load_seeds('0, '0);
    run_phase(60, 7, 120);
    load_seeds(rand64(), rand64());
    run_phase(60, 7, 200);
    load_seeds(64'd1, 64'h8000_0000_0000_0000);
    run_phase(0, 0, 200);
    check_seeds();

    $display("Requests taken: %0d offset, %0d range, %0d reseed, %0d ignored mode",
             offset_count, range_count, reseed_count, ignored_count);
    $display("Results checked: %0d; seed readbacks: %0d; mismatches: %0d",
             results_checked, readback_count, error_count);
    if (error_count == 0 && expected_values.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: %0d results still expected", expected_values.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
